/* src/drut_pkg.sv */
// shared types, codes and constants of the dirty region update tracker
package drut_pkg;

  // field widths
  localparam int COORD_W      = 13;
  localparam int RECT_W       = 12;
  localparam int PAGE_NUM_W   = 12;
  localparam int LINE_W       = 16;
  localparam int SCREEN_W     = 12;
  localparam int PAGES_W      = 11;
  localparam int INDEX_W      = 32;
  localparam int OUT_SLOT_W   = 6;
  localparam int KIND_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_DATA_W    = 96;
  localparam int OUT_DATA_W   = 64;

  // configuration reset values
  localparam logic [LINE_W-1:0]   LINE_BYTES_RST    = 16'd3200;
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd600;
  localparam logic [PAGES_W-1:0]  PAGES_IN_USE_RST  = 11'd512;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE  = 2'd3;

  // input item kinds
  typedef enum logic [KIND_W-1:0] {
    K_RECT    = 2'd0,
    K_FAULT   = 2'd1,
    K_TICK    = 2'd2,
    K_ADVANCE = 2'd3
  } in_kind_t;

  // result item kinds
  localparam logic [KIND_W-1:0] RES_UPDATE      = 2'd0;
  localparam logic [KIND_W-1:0] RES_FAULT_OK    = 2'd1;
  localparam logic [KIND_W-1:0] RES_FAULT_RANGE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_TICK   = 3'd1,
    S_DIV_LO = 3'd2,
    S_DIV_HI = 3'd3,
    S_PUSH   = 3'd4
  } state_t;

  // command to the damage box
  typedef struct packed {
    logic               grow;
    logic               clear;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } box_cmd_t;

  // current damage box
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    logic               armed;
  } box_view_t;

endpackage

/* src/drut_div.sv */
// serial restoring divider, one quotient bit per cycle
module drut_div #(
  parameter int DIVIDEND_W = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DIVIDEND_W-1:0]         dividend,
  input  logic [drut_pkg::LINE_W-1:0]   divisor,
  output logic                          done,
  output logic [DIVIDEND_W-1:0]         quotient
);
  import drut_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [LINE_W-1:0]     rem_r;
  logic [LINE_W-1:0]     rem_nxt;
  logic [LINE_W-1:0]     dvs_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVIDEND_W-1:0] quo_nxt;
  logic [LINE_W:0]       trial;
  logic [LINE_W:0]       diff;
  logic                  fits;

  // one trial subtraction step
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[LINE_W-1:0] : trial[LINE_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/drut_box.sv */
// damage box registers with union growth and clear
module drut_box (
  input  logic                clk,
  input  logic                rst_n,
  input  drut_pkg::box_cmd_t  cmd,
  output drut_pkg::box_view_t view
);
  import drut_pkg::*;

  logic [COORD_W-1:0] left_r, left_nxt;
  logic [COORD_W-1:0] right_r, right_nxt;
  logic [COORD_W-1:0] top_r, top_nxt;
  logic [COORD_W-1:0] bottom_r, bottom_nxt;
  logic               armed_r, armed_nxt;

  // union of box and region, an axis with far edge zero is replaced
  always_comb begin
    left_nxt   = left_r;
    right_nxt  = right_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    armed_nxt  = armed_r;
    priority if (cmd.clear) begin
      left_nxt   = '0;
      right_nxt  = '0;
      top_nxt    = '0;
      bottom_nxt = '0;
      armed_nxt  = 1'b0;
    end else if (cmd.grow) begin
      if (bottom_r == '0) begin
        top_nxt    = cmd.y1;
        bottom_nxt = cmd.y2;
      end else begin
        top_nxt    = (top_r > cmd.y1) ? cmd.y1 : top_r;
        bottom_nxt = (bottom_r < cmd.y2) ? cmd.y2 : bottom_r;
      end
      if (right_r == '0) begin
        left_nxt  = cmd.x1;
        right_nxt = cmd.x2;
      end else begin
        left_nxt  = (left_r > cmd.x1) ? cmd.x1 : left_r;
        right_nxt = (right_r < cmd.x2) ? cmd.x2 : right_r;
      end
      armed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
      armed_r  <= 1'b0;
    end else begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      armed_r  <= armed_nxt;
    end
  end

  assign view = '{left: left_r, right: right_r, top: top_r, bottom: bottom_r,
                  armed: armed_r};

endmodule

/* src/dirty_region_update_tracker_unit.sv */
// top level of the dirty region update tracker: sequencer, ring indexes, config
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | tuser kind, tdata rect/page/consumer
//  out_    | master    | out_tvalid/tready  | tuser result kind, tdata box and slot
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data
//
// rectangle and consumer advance items are taken in the idle state; a tick goes
// through the tick state, an out-of-range fault through the push state, and an
// in-range fault through two serial divider passes (low, high row) before push.
// reset is synchronous active low and leaves no clearing pass.
// a full output register holds only emitting ticks and faults; idle takes the rest.
module dirty_region_update_tracker_unit #(
  parameter int RING_SLOTS = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tdata: rect_left, rect_top, rect_width, rect_height, fault_page, consumer_index
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [drut_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: kind
  input  logic [drut_pkg::KIND_W-1:0]        in_tuser,
  // tdata: update_left, update_top, update_width, update_height, ring_slot
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [drut_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: result_kind
  output logic [drut_pkg::KIND_W-1:0]        out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [drut_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drut_pkg::LINE_W-1:0]        cfg_data
);
  import drut_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int DW     = PAGE_NUM_W + PAGE_W;
  localparam int SLOT_W = $clog2(RING_SLOTS);

  // configuration registers
  logic [LINE_W-1:0]   line_bytes_r;
  logic [SCREEN_W-1:0] screen_width_r;
  logic [SCREEN_W-1:0] screen_height_r;
  logic [PAGES_W-1:0]  pages_in_use_r;

  // input fields
  in_kind_t            kind;
  logic [RECT_W-1:0]   rect_left, rect_top, rect_width, rect_height;
  logic [PAGE_NUM_W-1:0] fault_page;
  logic [INDEX_W-1:0]  consumer_index;

  // sequencer
  state_t              state_r, state_nxt;
  logic                accept;
  logic                page_ok;
  logic                out_free;
  logic                tick_go;
  logic                emit;
  logic                push;
  logic                ld_base;
  logic                ld_qlo;
  logic [KIND_W-1:0]   pend_kind_r;

  // divider interface
  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [LINE_W-1:0]   div_divisor;
  logic                div_done;
  logic [DW-1:0]       div_q;
  logic [DW-1:0]       base_now;
  logic [DW-1:0]       base_r;
  logic [DW-1:0]       q_lo_r;
  logic [SCREEN_W-1:0] row_lo, row_hi;

  // box
  box_cmd_t            box_cmd;
  box_view_t           box_view;

  // ring
  logic [INDEX_W-1:0]  producer_r;
  logic [INDEX_W-1:0]  consumer_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                ring_full;

  // output register
  logic                    out_tvalid_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [OUT_DATA_W-1:0]   out_data_nxt;
  logic [KIND_W-1:0]       out_kind_nxt;

  // unpack input item
  assign kind           = in_kind_t'(in_tuser);
  assign rect_left      = in_tdata[11:0];
  assign rect_top       = in_tdata[23:12];
  assign rect_width     = in_tdata[35:24];
  assign rect_height    = in_tdata[47:36];
  assign fault_page     = in_tdata[59:48];
  assign consumer_index = in_tdata[91:60];

  // status terms
  assign accept    = in_tvalid && in_tready;
  assign page_ok   = (fault_page < PAGE_NUM_W'(pages_in_use_r));
  assign out_free  = !out_tvalid_r || out_tready;
  assign ring_full = ((producer_r - consumer_r) == INDEX_W'(RING_SLOTS));
  assign tick_go   = box_view.armed && !ring_full;
  assign base_now  = DW'(fault_page) * DW'(PAGE_BYTES);
  assign div_divisor = (line_bytes_r == '0) ? LINE_W'(1) : line_bytes_r;

  // clamp row range to the screen height
  assign row_lo = (q_lo_r > DW'(screen_height_r)) ? screen_height_r : q_lo_r[SCREEN_W-1:0];
  assign row_hi = (div_q > DW'(screen_height_r)) ? screen_height_r : div_q[SCREEN_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            K_RECT, K_ADVANCE: state_nxt = S_IDLE;
            K_FAULT:           state_nxt = page_ok ? S_DIV_LO : S_PUSH;
            K_TICK:            state_nxt = S_TICK;
          endcase
        end
      end
      S_TICK: begin
        if (!tick_go || out_free) state_nxt = S_IDLE;
      end
      S_DIV_LO: begin
        if (div_done) state_nxt = S_DIV_HI;
      end
      S_DIV_HI: begin
        if (div_done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = base_now;
    ld_base      = 1'b0;
    ld_qlo       = 1'b0;
    emit         = 1'b0;
    push         = 1'b0;
    box_cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && kind == K_RECT) begin
          box_cmd.grow = 1'b1;
          box_cmd.x1   = COORD_W'(rect_left);
          box_cmd.y1   = COORD_W'(rect_top);
          box_cmd.x2   = COORD_W'(rect_left) + COORD_W'(rect_width);
          box_cmd.y2   = COORD_W'(rect_top) + COORD_W'(rect_height);
        end
        if (in_tvalid && kind == K_FAULT && page_ok) begin
          div_start = 1'b1;
          ld_base   = 1'b1;
        end
      end
      S_TICK: begin
        if (tick_go && out_free) begin
          emit          = 1'b1;
          box_cmd.clear = 1'b1;
        end
      end
      S_DIV_LO: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = base_r + DW'(PAGE_BYTES - 1);
          ld_qlo       = 1'b1;
        end
      end
      S_DIV_HI: begin
        if (div_done) begin
          box_cmd.grow = 1'b1;
          box_cmd.x1   = '0;
          box_cmd.y1   = COORD_W'(row_lo);
          box_cmd.x2   = COORD_W'(screen_width_r);
          box_cmd.y2   = COORD_W'(row_hi);
        end
      end
      S_PUSH: begin
        push = out_free;
      end
      default: ;
    endcase
  end

  // result payload
  always_comb begin
    if (emit) begin
      out_kind_nxt = RES_UPDATE;
      out_data_nxt = {6'b0, OUT_SLOT_W'(slot_r),
                      box_view.bottom - box_view.top,
                      box_view.right - box_view.left,
                      box_view.top, box_view.left};
    end else begin
      out_kind_nxt = pend_kind_r;
      out_data_nxt = '0;
    end
  end

  // sequencer state and fault scratch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == K_FAULT) begin
      pend_kind_r <= page_ok ? RES_FAULT_OK : RES_FAULT_RANGE;
    end
    if (ld_base) base_r <= base_now;
    if (ld_qlo) q_lo_r <= div_q;
  end

  // ring indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      producer_r <= '0;
      consumer_r <= '0;
      slot_r     <= '0;
    end else begin
      if (emit) begin
        producer_r <= producer_r + 1'b1;
        if (slot_r == SLOT_W'(RING_SLOTS - 1) || producer_r == '1) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + 1'b1;
        end
      end
      if (accept && kind == K_ADVANCE) consumer_r <= consumer_index;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit || push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit || push) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r    <= LINE_BYTES_RST;
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      pages_in_use_r  <= PAGES_IN_USE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LINE_BYTES:    line_bytes_r    <= cfg_data;
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[SCREEN_W-1:0];
        CFG_PAGES_IN_USE:  pages_in_use_r  <= cfg_data[PAGES_W-1:0];
      endcase
    end
  end

  // shared row divider
  drut_div #(
    .DIVIDEND_W(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // damage box
  drut_box u_box (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (box_cmd),
    .view  (box_view)
  );

`ifndef SYNTHESIS
  // divider finishes only while a fault is being converted
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_LO || state_r == S_DIV_HI))
    else $error("divider done outside fault conversion");

  // an emitted box is cleared and disarmed
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (box_view.right == '0 && box_view.bottom == '0 && !box_view.armed))
    else $error("box not cleared after update event");

  // an update event needs an armed box and ring room
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (box_view.armed && !ring_full))
    else $error("update event with full ring or unarmed box");

  // an in-range fault starts the divider
  a_fault_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind == K_FAULT && page_ok) |=> (state_r == S_DIV_LO))
    else $error("in-range fault did not start row conversion");
`endif

endmodule

/* dv/drut_update_checker.sv */
// checker for the dirty region update tracker: predicts each result item and compares
module drut_update_checker #(
  parameter int RING_SLOTS = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [drut_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [drut_pkg::KIND_W-1:0]     in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [drut_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [drut_pkg::KIND_W-1:0]     out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [drut_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drut_pkg::LINE_W-1:0]     cfg_data,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import drut_pkg::*;

  // one result item as it leaves the block
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [COORD_W-1:0]    left;
    logic [COORD_W-1:0]    top;
    logic [COORD_W-1:0]    width;
    logic [COORD_W-1:0]    height;
    logic [OUT_SLOT_W-1:0] slot;
  } update_item_t;

  update_item_t expected_updates[$];
  int           mismatch_count = 0;

  // mirrored configuration
  logic [LINE_W-1:0]   line_bytes;
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;
  logic [PAGES_W-1:0]  pages_in_use;

  // mirrored damage box and ring indexes
  logic [COORD_W-1:0] box_left, box_right, box_top, box_bottom;
  logic               flush_armed;
  logic [INDEX_W-1:0] producer_idx, consumer_idx;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 30) $display("[%0t] checker: %s", $realtime, what);
  endtask

  // union of the box with a span; an axis with far edge zero is empty and replaced
  task automatic grow_damage(input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
                             input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] y2);
    if (box_bottom == '0) begin
      box_top    = y1;
      box_bottom = y2;
    end
    if (box_right == '0) begin
      box_left  = x1;
      box_right = x2;
    end
    if (box_top > y1) box_top = y1;
    if (box_bottom < y2) box_bottom = y2;
    if (box_left > x1) box_left = x1;
    if (box_right < x2) box_right = x2;
    flush_armed = 1'b1;
  endtask

  // page write fault: byte span to clamped row range, full screen width
  task automatic add_fault_rows(input logic [PAGE_NUM_W-1:0] page);
    longint unsigned lb, base, first_row, last_row;
    lb        = (line_bytes == '0) ? 1 : line_bytes;
    base      = longint'(page) * PAGE_BYTES;
    first_row = base / lb;
    last_row  = (base + PAGE_BYTES - 1) / lb;
    if (last_row > screen_height) last_row = screen_height;
    if (first_row > screen_height) first_row = screen_height;
    grow_damage('0, first_row[COORD_W-1:0], {1'b0, screen_width}, last_row[COORD_W-1:0]);
  endtask

  // work out the result of one accepted input item
  task automatic predict_item(input in_kind_t kind, input logic [IN_DATA_W-1:0] d);
    update_item_t       res;
    logic [RECT_W-1:0]  rl, rt, rw, rh;
    logic [PAGE_NUM_W-1:0] page;
    logic [INDEX_W-1:0] fill;
    res  = '0;
    rl   = d[11:0];
    rt   = d[23:12];
    rw   = d[35:24];
    rh   = d[47:36];
    page = d[59:48];
    case (kind)
      K_RECT: begin
        grow_damage({1'b0, rl}, {1'b0, rt}, {1'b0, rl} + {1'b0, rw}, {1'b0, rt} + {1'b0, rh});
      end
      K_FAULT: begin
        if (page >= pages_in_use) begin
          res.kind = RES_FAULT_RANGE;
        end else begin
          add_fault_rows(page);
          res.kind = RES_FAULT_OK;
        end
        expected_updates.push_back(res);
      end
      K_TICK: begin
        fill = producer_idx - consumer_idx;
        // unarmed or full ring: nothing leaves, box and arming kept
        if (flush_armed && fill != RING_SLOTS) begin
          res.kind   = RES_UPDATE;
          res.left   = box_left;
          res.top    = box_top;
          res.width  = box_right - box_left;
          res.height = box_bottom - box_top;
          res.slot   = OUT_SLOT_W'(producer_idx % RING_SLOTS);
          expected_updates.push_back(res);
          producer_idx = producer_idx + 1;
          box_left     = '0;
          box_right    = '0;
          box_top      = '0;
          box_bottom   = '0;
          flush_armed  = 1'b0;
        end
      end
      default: begin
        consumer_idx = d[91:60];
      end
    endcase
  endtask

  // watch config, input and result channels
  always @(posedge clk) begin
    update_item_t got, want;
    if (!rst_n) begin
      line_bytes    = LINE_BYTES_RST;
      screen_width  = SCREEN_WIDTH_RST;
      screen_height = SCREEN_HEIGHT_RST;
      pages_in_use  = PAGES_IN_USE_RST;
      box_left      = '0;
      box_right     = '0;
      box_top       = '0;
      box_bottom    = '0;
      flush_armed   = 1'b0;
      producer_idx  = '0;
      consumer_idx  = '0;
      expected_updates.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_BYTES:    line_bytes    = cfg_data;
          CFG_SCREEN_WIDTH:  screen_width  = cfg_data[SCREEN_W-1:0];
          CFG_SCREEN_HEIGHT: screen_height = cfg_data[SCREEN_W-1:0];
          CFG_PAGES_IN_USE:  pages_in_use  = cfg_data[PAGES_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_item(in_kind_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) begin
        got.kind   = out_tuser;
        got.left   = out_tdata[12:0];
        got.top    = out_tdata[25:13];
        got.width  = out_tdata[38:26];
        got.height = out_tdata[51:39];
        got.slot   = out_tdata[57:52];
        if (expected_updates.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing expected", got.kind));
        end else begin
          want = expected_updates.pop_front();
          if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.left != want.left)
            report_mismatch($sformatf("left %0d, expected %0d", got.left, want.left));
          if (got.top != want.top)
            report_mismatch($sformatf("top %0d, expected %0d", got.top, want.top));
          if (got.width != want.width)
            report_mismatch($sformatf("width %0d, expected %0d", got.width, want.width));
          if (got.height != want.height)
            report_mismatch($sformatf("height %0d, expected %0d", got.height, want.height));
          if (got.slot != want.slot)
            report_mismatch($sformatf("ring slot %0d, expected %0d", got.slot, want.slot));
        end
      end
    end
    pending <= expected_updates.size();
    errors  <= mismatch_count;
  end

endmodule

/* dv/tb_dirty_region_update_tracker_unit.sv */
// testbench top of the dirty region update tracker: stimulus, idling and verdict
module tb_dirty_region_update_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import drut_pkg::*;

  localparam int RING_SLOTS   = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int ITEM_LAT     = 2 * (12 + $clog2(PAGE_BYTES)) + 4;
  localparam int SEGMENTS     = 8;
  localparam int RANDOM_ITEMS = 950;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LINE_W-1:0]     cfg_data = '0;

  int errors, pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int updates_seen = 0;
  int settings_used = 1;
  int drain_cycles;
  logic [PAGES_W-1:0] pages_now = PAGES_IN_USE_RST;

  always #5 clk = ~clk;

  dirty_region_update_tracker_unit #(
    .RING_SLOTS(RING_SLOTS),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  drut_update_checker #(
    .RING_SLOTS(RING_SLOTS),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // receiver stalls at random
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_stall_pct);

  // count results, the update count steers the consumer index
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser == RES_UPDATE) updates_seen++;
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("run limit reached with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_in(
    input logic [RECT_W-1:0] left, input logic [RECT_W-1:0] top,
    input logic [RECT_W-1:0] width, input logic [RECT_W-1:0] height,
    input logic [PAGE_NUM_W-1:0] page, input logic [INDEX_W-1:0] consumer);
    return {4'b0, consumer, page, height, width, top, left};
  endfunction

  // one item, with a random gap in front of it
  task automatic send_item(input in_kind_t kind, input logic [IN_DATA_W-1:0] d);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // random item, well-formed most of the time, other fields filled with noise
  task automatic send_random_item();
    int                    pick;
    logic [RECT_W-1:0]     l, t, w, h;
    logic [PAGE_NUM_W-1:0] p;
    logic [INDEX_W-1:0]    c;
    in_kind_t              kind;
    pick = $urandom_range(99);
    l = RECT_W'($urandom);
    t = RECT_W'($urandom);
    w = RECT_W'($urandom);
    h = RECT_W'($urandom);
    p = PAGE_NUM_W'($urandom);
    c = $urandom;
    if (pick < 35) begin
      kind = K_RECT;
      if ($urandom_range(9) < 7) begin
        l = RECT_W'($urandom_range(1023));
        t = RECT_W'($urandom_range(1023));
        w = RECT_W'($urandom_range(255));
        h = RECT_W'($urandom_range(255));
      end
      if ($urandom_range(9) == 0) w = '0;
      if ($urandom_range(9) == 0) h = '0;
      if ($urandom_range(19) == 0) l = '0;
      if ($urandom_range(19) == 0) t = '0;
    end else if (pick < 60) begin
      kind = K_FAULT;
      if (pages_now != '0 && $urandom_range(9) < 8)
        p = PAGE_NUM_W'($urandom_range(pages_now - 1));
    end else if (pick < 85) begin
      kind = K_TICK;
    end else begin
      kind = K_ADVANCE;
      pick = $urandom_range(99);
      // mostly a consumer close behind, sometimes far enough back to fill the ring
      if (pick < 50) c = INDEX_W'(updates_seen - $urandom_range(8));
      else if (pick < 85) c = INDEX_W'(updates_seen - $urandom_range(64, 56));
    end
    send_item(kind, pack_in(l, t, w, h, p, c));
  endtask

  // let every expected result come out, then give ignored items time to settle
  task automatic drain_block();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2 * ITEM_LAT + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LINE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PAGES_IN_USE) pages_now = value[PAGES_W-1:0];
  endtask

  task automatic apply_setting(input logic [LINE_W-1:0] lb, input logic [LINE_W-1:0] sw,
                               input logic [LINE_W-1:0] sh, input logic [LINE_W-1:0] pg);
    drain_block();
    write_reg(CFG_LINE_BYTES, lb);
    write_reg(CFG_SCREEN_WIDTH, sw);
    write_reg(CFG_SCREEN_HEIGHT, sh);
    write_reg(CFG_PAGES_IN_USE, pg);
    settings_used++;
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at reset settings
    send_item(K_ADVANCE, pack_in(0, 0, 0, 0, 0, 32'h0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    // empty rectangle still arms, tick emits an empty box
    send_item(K_RECT, pack_in(0, 0, 0, 0, 0, 0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    // extreme rectangle unioned with a small one
    send_item(K_RECT, pack_in(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF));
    send_item(K_RECT, pack_in(10, 20, 5, 5, 0, 0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    // one empty axis gets replaced by the next rectangle
    send_item(K_RECT, pack_in(0, 5, 0, 10, 0, 0));
    send_item(K_RECT, pack_in(50, 1, 10, 2, 0, 0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    // faults in range, at the limit and beyond
    send_item(K_FAULT, pack_in(0, 0, 0, 0, 0, 0));
    send_item(K_FAULT, pack_in(0, 0, 0, 0, 511, 0));
    send_item(K_FAULT, pack_in(0, 0, 0, 0, 512, 0));
    send_item(K_FAULT, pack_in(0, 0, 0, 0, 12'hFFF, 0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    // page wholly below the screen, then a page inside it
    send_item(K_FAULT, pack_in(0, 0, 0, 0, 500, 0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    send_item(K_FAULT, pack_in(0, 0, 0, 0, 400, 0));
    send_item(K_RECT, pack_in(700, 300, 200, 400, 0, 0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    // consumer far out of step, ring counts as not full
    send_item(K_ADVANCE, pack_in(0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(K_RECT, pack_in(1, 2, 3, 4, 0, 0));
    send_item(K_TICK, pack_in(0, 0, 0, 0, 0, 0));
    send_item(K_ADVANCE, pack_in(0, 0, 0, 0, 0, 32'h5));

    // random segments, each with its own setting and idling phase
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        1: apply_setting(16'd1, 16'd4095, 16'd4095, 16'd1024);
        2: apply_setting(16'hFFFF, 16'd1, 16'd1, 16'd1);
        3: apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
        4: apply_setting(16'd640, 16'hFFFF, 16'hF258, 16'hFFFF);
        5: apply_setting(16'd3200, 16'd800, 16'd600, 16'd512);
        6: apply_setting(LINE_W'($urandom_range(8192, 1)), LINE_W'($urandom),
                         LINE_W'($urandom), LINE_W'($urandom));
        7: apply_setting(LINE_W'($urandom), LINE_W'($urandom),
                         LINE_W'($urandom), LINE_W'($urandom));
        default: ;
      endcase
      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      repeat (RANDOM_ITEMS / SEGMENTS) send_random_item();
    end

    // wind down
    in_tvalid <= 1'b0;
    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 100000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (2 * ITEM_LAT + 20) @(posedge clk);

    $display("covered %0d input items under %0d register settings", items_sent, settings_used);
    $display("%0d result items seen, %0d of them update events", results_seen, updates_seen);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
